// ===== hdl/opcode_length_frame_deframer_assert.svh =====
// Assertion macros used by the checker file of the frame deframer.
`ifndef OPCODE_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define OPCODE_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

// A property checked on every rising edge of aclk while aresetn is high.
`define OLFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// A signal holds its value in the cycle after a stalled word.
`define OLFD_ASSERT_HOLD(lbl, stall, sig, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (stall) |=> $stable(sig)) else $error(msg);

`endif

// ===== hdl/olfd_pkg.sv =====
`default_nettype none

package olfd_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned HDR_LAST = 5;

    localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'h0001_0000;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_FAILED = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [15:0] frame_opcode;
        logic [31:0] frame_length;
        logic [7:0] payload_byte;
        logic last_of_frame;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/olfd_regs.sv =====
`default_nettype none

module olfd_regs (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [olfd_pkg::PADDR_W-1:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    output logic [31:0] max_len
);
    import olfd_pkg::*;

    logic [31:0] max_len_reg;
    logic [31:0] max_len_next;
    logic [0:0] reg_index;
    logic wr_en;

    assign reg_index = paddr[PADDR_W-1:PADDR_W-1];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        max_len_next = max_len_reg;
        if (wr_en && (reg_index == REG_MAX_PAYLOAD)) begin
            max_len_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_PAYLOAD_RST;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (reg_index == REG_MAX_PAYLOAD) begin
            prdata = max_len_reg;
        end
    end

    assign max_len = max_len_reg;

endmodule

`default_nettype wire

// ===== hdl/olfd_outbuf.sv =====
`default_nettype none

module olfd_outbuf (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic push,
    input wire olfd_pkg::res_t push_res,
    output logic push_ready,
    output logic out_valid,
    output olfd_pkg::res_t out_res,
    input wire logic out_ready
);
    import olfd_pkg::*;

    logic main_valid_reg;
    logic main_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t main_res_reg;
    res_t main_res_next;
    res_t skid_res_reg;
    res_t skid_res_next;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_res_next = main_res_reg;
        skid_res_next = skid_res_reg;
        if (out_ready || !main_valid_reg) begin
            main_valid_next = skid_valid_reg || push;
            main_res_next = skid_valid_reg ? skid_res_reg : push_res;
            skid_valid_next = 1'b0;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_res_next = push_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_res_reg <= main_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res = main_res_reg;

endmodule

`default_nettype wire

// ===== hdl/opcode_length_frame_deframer.sv =====
// Channel   Direction  Word
// s_        in         one stream byte
// m_        out        header, payload byte or oversized-length error
// cfg       in         APB write of max_payload_bytes
//
// One byte is taken every cycle while s_ready is high; any word it completes is registered in the cycle it is accepted.
// s_ready falls only when both the output register and its skid stage hold words.
// Reset is synchronous and active low; it restores the header phase and the default limit.
// After an oversized length the block accepts and drops bytes until reset.
`default_nettype none

module opcode_length_frame_deframer (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire logic [7:0] s_stream_byte,
    output logic m_valid,
    input wire logic m_ready,
    output logic [1:0] m_event_kind,
    output logic [15:0] m_frame_opcode,
    output logic [31:0] m_frame_length,
    output logic [7:0] m_payload_byte,
    output logic m_last_of_frame,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [olfd_pkg::PADDR_W-1:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import olfd_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    logic [2:0] hdr_cnt_reg;
    logic [2:0] hdr_cnt_next;
    logic [15:0] opcode_reg;
    logic [15:0] opcode_next;
    logic [31:0] length_reg;
    logic [31:0] length_next;
    logic [31:0] remain_reg;
    logic [31:0] remain_next;

    logic [31:0] max_len;
    logic accept;
    logic hdr_done;
    logic [15:0] opcode_upd;
    logic [31:0] length_upd;
    logic push;
    logic push_ready;
    res_t push_res;
    res_t out_res;

    olfd_regs u_regs (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .max_len(max_len)
    );

    assign s_ready = push_ready;
    assign accept = s_valid && push_ready;
    assign hdr_done = (hdr_cnt_reg == 3'(HDR_LAST));

    always_comb begin
        opcode_upd = opcode_reg;
        length_upd = length_reg;
        if (hdr_cnt_reg < 3'd2) begin
            opcode_upd = {opcode_reg[7:0], s_stream_byte};
        end else begin
            length_upd = {length_reg[23:0], s_stream_byte};
        end
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HEADER: begin
                if (accept && hdr_done) begin
                    if (length_upd > max_len) begin
                        phase_next = PH_FAILED;
                    end else if (length_upd != 32'd0) begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (accept && (remain_reg == 32'd1)) begin
                    phase_next = PH_HEADER;
                end
            end
            PH_FAILED: begin
                phase_next = PH_FAILED;
            end
            default: begin
                phase_next = PH_FAILED;
            end
        endcase
    end

    always_comb begin
        hdr_cnt_next = hdr_cnt_reg;
        opcode_next = opcode_reg;
        length_next = length_reg;
        remain_next = remain_reg;
        push = 1'b0;
        push_res.event_kind = KIND_HEADER;
        push_res.frame_opcode = opcode_reg;
        push_res.frame_length = length_reg;
        push_res.payload_byte = 8'd0;
        push_res.last_of_frame = 1'b0;
        case (phase_reg)
            PH_HEADER: begin
                if (accept) begin
                    opcode_next = opcode_upd;
                    length_next = length_upd;
                    if (hdr_done) begin
                        hdr_cnt_next = 3'd0;
                        push = 1'b1;
                        push_res.frame_opcode = opcode_upd;
                        push_res.frame_length = length_upd;
                        if (length_upd > max_len) begin
                            push_res.event_kind = KIND_ERROR;
                            push_res.last_of_frame = 1'b1;
                        end else if (length_upd == 32'd0) begin
                            push_res.last_of_frame = 1'b1;
                        end else begin
                            remain_next = length_upd;
                        end
                    end else begin
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (accept) begin
                    remain_next = remain_reg - 32'd1;
                    push = 1'b1;
                    push_res.event_kind = KIND_PAYLOAD;
                    push_res.payload_byte = s_stream_byte;
                    push_res.last_of_frame = (remain_reg == 32'd1);
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hdr_cnt_reg <= 3'd0;
            opcode_reg <= 16'd0;
            length_reg <= 32'd0;
            remain_reg <= 32'd0;
        end else begin
            phase_reg <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            opcode_reg <= opcode_next;
            length_reg <= length_next;
            remain_reg <= remain_next;
        end
    end

    olfd_outbuf u_outbuf (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .push_res(push_res),
        .push_ready(push_ready),
        .out_valid(m_valid),
        .out_res(out_res),
        .out_ready(m_ready)
    );

    assign m_event_kind = out_res.event_kind;
    assign m_frame_opcode = out_res.frame_opcode;
    assign m_frame_length = out_res.frame_length;
    assign m_payload_byte = out_res.payload_byte;
    assign m_last_of_frame = out_res.last_of_frame;

endmodule

`default_nettype wire

// ===== hdl/olfd_checker.sv =====
`default_nettype none
`include "opcode_length_frame_deframer_assert.svh"

module olfd_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic [1:0] m_event_kind,
    input wire logic [7:0] m_payload_byte,
    input wire logic m_last_of_frame
);
    import olfd_pkg::*;

    `OLFD_ASSERT_HOLD(a_out_hold, m_valid && !m_ready, m_valid, "Stalled output word dropped.")
    `OLFD_ASSERT(a_kind_legal, m_valid |-> (m_event_kind == KIND_HEADER || m_event_kind == KIND_PAYLOAD || m_event_kind == KIND_ERROR), "Illegal event kind.")
    `OLFD_ASSERT(a_byte_zero, (m_valid && m_event_kind != KIND_PAYLOAD) |-> (m_payload_byte == 8'd0), "Payload byte set on a non-payload word.")
    `OLFD_ASSERT(a_error_last, (m_valid && m_event_kind == KIND_ERROR) |-> m_last_of_frame, "Error word not marked last.")

endmodule

bind opcode_length_frame_deframer olfd_checker u_olfd_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_event_kind(m_event_kind),
    .m_payload_byte(m_payload_byte),
    .m_last_of_frame(m_last_of_frame)
);

`default_nettype wire
